// ----- rtl/msf_pkg.sv -----
package msf_pkg;

	localparam int unsigned BYTE_W = 8;

	typedef enum logic [1:0] {
		CMD_TEXT    = 2'd0,
		CMD_PATTERN = 2'd1,
		CMD_CLEAR   = 2'd2
	} cmd_t;

	// Per-cell control, driven by the top level each cycle
	typedef struct packed {
		logic load;     // shift a pattern character into this cell
		logic commit;   // latch the length of the pattern just built
		logic advance;  // compare stage moves on (no output stall)
		logic compare;  // a text byte enters the compare stage
	} cell_ctl_t;

endpackage

// ----- rtl/msf_cell.sv -----
module msf_cell
	import msf_pkg::*;
#(
	parameter int unsigned PatternLen = 16,
	parameter int unsigned LenW       = 5
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cell_ctl_t                        ctl,
	input  logic [BYTE_W-1:0]                byte_value,
	input  logic [LenW-1:0]                  commit_len,
	input  logic [PatternLen-1:0][BYTE_W-1:0] window,
	input  logic [LenW-1:0]                  fill,
	input  logic                             valid,
	input  logic                             any_in,
	output logic                             any_out
);

	// Characters are kept newest first, so slot j lines up with window slot j
	logic [PatternLen-1:0][BYTE_W-1:0] chars_q;
	logic [LenW-1:0]                   len_q;
	logic                              hit_c;
	logic                              hit_s1;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			chars_q[0] <= byte_value;
			for (int j = 1; j < PatternLen; j++) begin
				chars_q[j] <= chars_q[j-1];
			end
		end
		if (ctl.commit) begin
			len_q <= commit_len;
		end
	end

	always_comb begin
		hit_c = valid && (len_q != '0) && (len_q <= fill);
		for (int j = 0; j < PatternLen; j++) begin
			if ((LenW'(j) < len_q) && (chars_q[j] != window[j])) begin
				hit_c = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s1 <= 1'b0;
		end else if (ctl.advance) begin
			hit_s1 <= ctl.compare & hit_c;
		end
	end

	// Hand the running match flag on to the next cell
	assign any_out = any_in | hit_s1;

endmodule

// ----- rtl/multi_pattern_substring_filter_unit.sv -----
// Result path: a text byte marked last passes the compare stage, then the result register.
// Throughput: one input item per cycle; input is held back only while the result
// register is full, not taken, and a text end sits in the compare stage.
// Reset (arst_n low): window, counts, match flag and valid flags clear,
// filter_enable returns to 1; stored pattern characters and lengths are undefined.
module multi_pattern_substring_filter_unit
	import msf_pkg::*;
#(
	parameter int unsigned MAX_PATTERNS    = 64,
	parameter int unsigned MAX_PATTERN_LEN = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
	input  logic [1:0]  s_axis_tuser,   // [1:0] command
	input  logic        s_axis_tlast,   // last
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [0] matched, [7:1] zero
	// filter_enable register
	input  logic        cfg_we,
	input  logic [0:0]  cfg_wdata
);

	localparam int unsigned LEN_W = $clog2(MAX_PATTERN_LEN + 1);
	localparam int unsigned CNT_W = $clog2(MAX_PATTERNS + 1);

	// Sliding text window, newest byte in slot 0
	logic [MAX_PATTERN_LEN-1:0][BYTE_W-1:0] window_q;
	logic [MAX_PATTERN_LEN-1:0][BYTE_W-1:0] window_nx;
	logic [LEN_W-1:0]                       fill_q;
	logic [LEN_W-1:0]                       fill_nx;

	// Pattern table bookkeeping
	logic [CNT_W-1:0] count_q;
	logic [LEN_W-1:0] build_q;
	logic             room;
	logic             full;
	logic [LEN_W-1:0] build_nx;

	// Compare stage and result register
	logic             s1_valid_s1;
	logic             s1_last_s1;
	logic             match_seen_q;
	logic             out_valid_q;
	logic             out_matched_q;
	logic             filter_enable_q;

	logic             stall;
	logic             advance;
	logic             fire;
	cmd_t             cmd;
	logic             is_text;
	logic             is_pat;
	logic [MAX_PATTERNS:0] any_chain;
	logic             any_hit;

	assign cmd     = cmd_t'(s_axis_tuser);
	// Stall only when a text end in the compare stage has nowhere to go
	assign stall   = s1_valid_s1 & s1_last_s1 & out_valid_q & ~m_axis_tready;
	assign advance = ~stall;
	assign fire    = s_axis_tvalid & advance;
	assign is_text = fire & (cmd == CMD_TEXT);
	assign is_pat  = fire & (cmd == CMD_PATTERN);

	assign s_axis_tready = advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_matched_q};

	// Window after the incoming byte shifts in; cells compare against this
	always_comb begin
		window_nx[0] = s_axis_tdata;
		for (int j = 1; j < MAX_PATTERN_LEN; j++) begin
			window_nx[j] = window_q[j-1];
		end
	end

	assign fill_nx  = (fill_q == LEN_W'(MAX_PATTERN_LEN)) ? fill_q : fill_q + LEN_W'(1);
	assign room     = (build_q < LEN_W'(MAX_PATTERN_LEN));
	assign full     = (count_q == CNT_W'(MAX_PATTERNS));
	// Characters past the maximum length are dropped, so the count stops there
	assign build_nx = build_q + LEN_W'(room);

	// Row of pattern cells; the match flag ripples from cell to cell
	assign any_chain[0] = 1'b0;

	for (genvar n = 0; n < MAX_PATTERNS; n++) begin : g_cell
		cell_ctl_t ctl;
		logic      slot_sel;

		// Slot under construction is the one at the current count
		assign slot_sel    = (count_q == CNT_W'(n));
		assign ctl.load    = is_pat & room & slot_sel;
		assign ctl.commit  = is_pat & s_axis_tlast & slot_sel;
		assign ctl.advance = advance;
		assign ctl.compare = is_text;

		msf_cell #(
			.PatternLen (MAX_PATTERN_LEN),
			.LenW       (LEN_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.byte_value (s_axis_tdata),
			.commit_len (build_nx),
			.window     (window_nx),
			.fill       (fill_nx),
			.valid      (CNT_W'(n) < count_q),
			.any_in     (any_chain[n]),
			.any_out    (any_chain[n+1])
		);
	end

	assign any_hit = any_chain[MAX_PATTERNS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q        <= '0;
			fill_q          <= '0;
			count_q         <= '0;
			build_q         <= '0;
			s1_valid_s1     <= 1'b0;
			s1_last_s1      <= 1'b0;
			match_seen_q    <= 1'b0;
			out_valid_q     <= 1'b0;
			out_matched_q   <= 1'b0;
			filter_enable_q <= 1'b1;
		end else begin
			if (cfg_we) begin
				filter_enable_q <= cfg_wdata[0];
			end

			if (fire) begin
				case (cmd)
					CMD_TEXT: begin
						// Drop the window at the end of a text; compare already saw it
						if (s_axis_tlast) begin
							window_q <= '0;
							fill_q   <= '0;
						end else begin
							window_q <= window_nx;
							fill_q   <= fill_nx;
						end
					end
					CMD_PATTERN: begin
						if (s_axis_tlast) begin
							build_q <= '0;
							if (!full) begin
								count_q <= count_q + CNT_W'(1);
							end
						end else begin
							build_q <= build_nx;
						end
					end
					CMD_CLEAR: begin
						count_q <= '0;
						build_q <= '0;
					end
					default: begin
						// unused command: ignore
					end
				endcase
			end

			if (advance) begin
				s1_valid_s1 <= is_text;
				s1_last_s1  <= s_axis_tlast;
			end

			// Load the result register at a text end, else empty it once taken
			if (advance & s1_valid_s1 & s1_last_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q & m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			// Fold the cell flags into the text's match state; report at text end
			if (advance & s1_valid_s1) begin
				if (s1_last_s1) begin
					out_matched_q <= (match_seen_q | any_hit) & filter_enable_q;
					match_seen_q  <= 1'b0;
				end else begin
					match_seen_q  <= match_seen_q | any_hit;
				end
			end
		end
	end

	// Table never holds more than its capacity
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_PATTERNS))
		else $error("pattern count beyond capacity");

	// Build length never passes the maximum pattern length
	a_build_range: assert property (@(posedge clk) disable iff (!arst_n)
		build_q <= LEN_W'(MAX_PATTERN_LEN))
		else $error("build length beyond maximum");

	// Input is held back only behind a waiting result and a text end in compare
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (s1_valid_s1 && s1_last_s1 && out_valid_q))
		else $error("input held without a pending text end");

	// An empty window holds only zeros
	a_window_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == '0) |-> (window_q == '0))
		else $error("window not cleared with its fill count");

endmodule
